FILE: design/pcvcs_pkg.sv
// Shared types for the point cloud voxel coverage statistics core.
// Holds the payload structs, register indexes and controller/datapath links.
// No dependencies.
package pcvcs_pkg;

    typedef struct packed {
        logic               action;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic [31:0] mean_error;
        logic [47:0] squared_dev_sum;
        logic [31:0] accepted_points;
        logic [15:0] covered_cells;
    } out_item_t;

    localparam logic [2:0] REG_BOX_MIN_X     = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y     = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z     = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X     = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y     = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z     = 3'd5;
    localparam logic [2:0] REG_INV_CELL_SIZE = 3'd6;
    localparam logic [2:0] REG_GROUND_BAND   = 3'd7;

    localparam logic       ACTION_POINT = 1'b0;
    localparam logic       ACTION_CLEAR = 1'b1;

    localparam logic [31:0] INV_CELL_RESET = 32'd65536;
    localparam logic [30:0] BAND_RESET     = 31'd6554;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic       load_point;
        logic       prep;
        logic       sq_issue;
        axis_t      sq_axis;
        logic       sq_acc;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       decide;
        logic       div_init;
        logic       div_step;
        logic       mean_upd;
        logic       dev_issue;
        logic       dev_acc;
        logic       proj_issue;
        axis_t      proj_axis;
        logic       proj_cap;
        axis_t      cap_axis;
        logic       mark_rd;
        logic [2:0] voxel;
        logic       mark_wr;
        logic       clr_step;
        logic       clr_stats;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic counted;
        logic clr_last;
    } status_t;

endpackage

FILE: design/pcvcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pcvcs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/pcvcs_datapath.sv
// Datapath: configuration registers, distance, square root, divider,
// statistics, grid projection and the voxel map. Uses pcvcs_pkg and pcvcs_ram.
module pcvcs_datapath
    import pcvcs_pkg::*;
#(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  in_item_t    in_data,
    input  cmd_t        cmd,
    output status_t     stat,
    output out_item_t   out_data
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int ZW    = $clog2(GRID_Z);

    function automatic logic signed [32:0] diff33(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        return $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    function automatic logic [32:0] mag33(logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [30:0] outside(logic signed [31:0] lo,
                                            logic signed [31:0] hi,
                                            logic signed [31:0] p);
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [32:0] d;
        a = diff33(lo, p);
        b = diff33(p, hi);
        d = a[32] ? 33'sd0 : a;
        if (b > d)
        begin
            d = b;
        end
        if (d > 33'sh07FFFFFFF)
        begin
            d = 33'sh07FFFFFFF;
        end
        return d[30:0];
    endfunction

    function automatic logic [32:0] umin33(logic [32:0] a, logic [32:0] b);
        return (a < b) ? a : b;
    endfunction

    logic signed [31:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [31:0] max_x_reg, max_y_reg, max_z_reg;
    logic [31:0]        inv_reg;
    logic [30:0]        band_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [30:0]        dx_reg, dy_reg, dz_reg;
    logic [32:0]        lin_reg, floor_reg;
    logic [63:0]        prod_reg, sq_reg;
    logic [63:0]        sv_reg, sr_reg, sb_reg;
    logic               counted_reg;
    logic [30:0]        surf_reg;
    logic               dneg_reg;
    logic [30:0]        dmag_reg;
    logic [30:0]        q_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        count_reg;
    logic [30:0]        mean_reg;
    logic [47:0]        dev_reg;
    logic [15:0]        hits_reg;
    logic [XW-1:0]      fx_reg, cx_reg;
    logic [YW-1:0]      fy_reg, cy_reg;
    logic [ZW-1:0]      fz_reg, cz_reg;
    logic [2:0]         okf_reg, okc_reg;
    logic [AW-1:0]      mk_addr_reg;
    logic               mk_ok_reg, mk_surf_reg;
    logic [AW-1:0]      clr_cnt_reg;
    out_item_t          out_reg;

    logic signed [32:0] dpx, dpy, dpz, dsel;
    logic [32:0]        msel;
    logic [31:0]        mul_a, mul_b;
    logic [32:0]        dobj, surf;
    logic signed [31:0] e2;
    logic [30:0]        e2mag;
    logic [63:0]        sq_t;
    logic [32:0]        trial;
    logic [33:0]        ip;
    logic [34:0]        ce;
    logic               fr, neg, ok_f, ok_c;
    logic [8:0]         gsel;
    logic [XW-1:0]      vx;
    logic [YW-1:0]      vy;
    logic [ZW-1:0]      vz;
    logic [AW-1:0]      vaddr;
    logic               ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]      ram_waddr;
    logic [48:0]        dev_sum;
    logic signed [31:0] delta;

    assign dpx = diff33(px_reg, min_x_reg);
    assign dpy = diff33(py_reg, min_y_reg);
    assign dpz = diff33(pz_reg, min_z_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_issue)
        begin
            case (cmd.sq_axis)
                AXIS_X:  mul_a = {1'b0, dx_reg};
                AXIS_Y:  mul_a = {1'b0, dy_reg};
                AXIS_Z:  mul_a = {1'b0, dz_reg};
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end
        else if (cmd.proj_issue)
        begin
            case (cmd.proj_axis)
                AXIS_X:  mul_a = 32'(mag33(dpx));
                AXIS_Y:  mul_a = 32'(mag33(dpy));
                AXIS_Z:  mul_a = 32'(mag33(dpz));
                default: mul_a = '0;
            endcase
            mul_b = inv_reg;
        end
        else if (cmd.dev_issue)
        begin
            mul_a = {1'b0, dmag_reg};
            mul_b = {1'b0, e2mag};
        end
    end

    assign dobj  = sr_reg[32:0];
    assign surf  = (dobj > lin_reg) ? dobj : lin_reg;
    assign delta = $signed({1'b0, surf[30:0]}) - $signed({1'b0, mean_reg});
    assign e2    = $signed({1'b0, surf_reg}) - $signed({1'b0, mean_reg});
    assign e2mag = e2[31] ? 31'(-e2) : e2[30:0];
    assign sq_t  = sr_reg + sb_reg;
    assign trial = {rem_reg, q_reg[30]};

    always_comb
    begin
        case (cmd.cap_axis)
            AXIS_X:
            begin
                dsel = dpx;
                gsel = 9'(GRID_X);
            end
            AXIS_Y:
            begin
                dsel = dpy;
                gsel = 9'(GRID_Y);
            end
            AXIS_Z:
            begin
                dsel = dpz;
                gsel = 9'(GRID_Z);
            end
            default:
            begin
                dsel = dpx;
                gsel = 9'(GRID_X);
            end
        endcase
        msel = mag33(dsel);
        neg  = dsel[32];
        ip   = {2'b0, prod_reg[63:32]} + (msel[32] ? {2'b0, inv_reg} : 34'd0);
        fr   = |prod_reg[31:0];
        ce   = {1'b0, ip} + 35'(fr);
        ok_f = neg ? (ip == 34'd0 && !fr) : (ip < 34'(gsel));
        ok_c = neg ? (ip == 34'd0) : (ce < 35'(gsel));
    end

    assign vx    = cmd.voxel[2] ? cx_reg : fx_reg;
    assign vy    = cmd.voxel[1] ? cy_reg : fy_reg;
    assign vz    = cmd.voxel[0] ? cz_reg : fz_reg;
    assign vaddr = (AW'(vx) * AW'(GRID_Y) + AW'(vy)) * AW'(GRID_Z) + AW'(vz);

    assign dev_sum = {1'b0, dev_reg} + {3'b0, prod_reg[61:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
            max_z_reg <= '0;
            inv_reg   <= INV_CELL_RESET;
            band_reg  <= BAND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOX_MIN_X:     min_x_reg <= cfg_data;
                REG_BOX_MIN_Y:     min_y_reg <= cfg_data;
                REG_BOX_MIN_Z:     min_z_reg <= cfg_data;
                REG_BOX_MAX_X:     max_x_reg <= cfg_data;
                REG_BOX_MAX_Y:     max_y_reg <= cfg_data;
                REG_BOX_MAX_Z:     max_z_reg <= cfg_data;
                REG_INV_CELL_SIZE: inv_reg   <= cfg_data;
                REG_GROUND_BAND:   band_reg  <= cfg_data[30:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            mean_reg    <= '0;
            dev_reg     <= '0;
            hits_reg    <= '0;
            clr_cnt_reg <= '0;
            counted_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (cmd.decide)
            begin
                counted_reg <= (floor_reg >= surf) && (floor_reg < {2'b0, band_reg});
                if ((floor_reg >= surf) && (floor_reg < {2'b0, band_reg})
                    && count_reg != 32'hFFFF_FFFF)
                begin
                    count_reg <= count_reg + 32'd1;
                end
            end
            if (cmd.mean_upd)
            begin
                mean_reg <= dneg_reg ? mean_reg - q_reg : mean_reg + q_reg;
            end
            if (cmd.dev_acc)
            begin
                dev_reg <= dev_sum[48] ? 48'hFFFF_FFFF_FFFF : dev_sum[47:0];
            end
            if (cmd.mark_wr && mk_ok_reg && !ram_rdata && mk_surf_reg
                && hits_reg != 16'hFFFF)
            begin
                hits_reg <= hits_reg + 16'd1;
            end
            if (cmd.clr_stats)
            begin
                count_reg <= '0;
                mean_reg  <= '0;
                dev_reg   <= '0;
                hits_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load_point)
        begin
            px_reg <= in_data.point_x;
            py_reg <= in_data.point_y;
            pz_reg <= in_data.point_z;
        end
        if (cmd.prep)
        begin
            dx_reg    <= outside(min_x_reg, max_x_reg, px_reg);
            dy_reg    <= outside(min_y_reg, max_y_reg, py_reg);
            dz_reg    <= outside(min_z_reg, max_z_reg, pz_reg);
            floor_reg <= mag33(diff33(min_z_reg, pz_reg));
            lin_reg   <= umin33(umin33(mag33(diff33(min_x_reg, px_reg)),
                                       mag33(diff33(max_x_reg, px_reg))),
                                umin33(umin33(mag33(diff33(min_y_reg, py_reg)),
                                              mag33(diff33(max_y_reg, py_reg))),
                                       umin33(mag33(diff33(min_z_reg, pz_reg)),
                                              mag33(diff33(max_z_reg, pz_reg)))));
            sq_reg    <= '0;
        end
        if (cmd.sq_acc)
        begin
            sq_reg <= sq_reg + prod_reg;
        end
        if (cmd.sqrt_init)
        begin
            sv_reg <= sq_reg;
            sr_reg <= '0;
            sb_reg <= 64'h4000_0000_0000_0000;
        end
        if (cmd.sqrt_step)
        begin
            if (sv_reg >= sq_t)
            begin
                sv_reg <= sv_reg - sq_t;
                sr_reg <= (sr_reg >> 1) + sb_reg;
            end
            else
            begin
                sr_reg <= sr_reg >> 1;
            end
            sb_reg <= sb_reg >> 2;
        end
        if (cmd.decide)
        begin
            surf_reg <= surf[30:0];
            dneg_reg <= delta[31];
            dmag_reg <= delta[31] ? 31'(-delta) : delta[30:0];
        end
        if (cmd.div_init)
        begin
            q_reg   <= dmag_reg;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, count_reg})
            begin
                rem_reg <= 32'(trial - {1'b0, count_reg});
                q_reg   <= {q_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                q_reg   <= {q_reg[29:0], 1'b0};
            end
        end
        if (cmd.proj_cap)
        begin
            case (cmd.cap_axis)
                AXIS_X:
                begin
                    fx_reg     <= neg ? '0 : ip[XW-1:0];
                    cx_reg     <= neg ? '0 : ce[XW-1:0];
                    okf_reg[2] <= ok_f;
                    okc_reg[2] <= ok_c;
                end
                AXIS_Y:
                begin
                    fy_reg     <= neg ? '0 : ip[YW-1:0];
                    cy_reg     <= neg ? '0 : ce[YW-1:0];
                    okf_reg[1] <= ok_f;
                    okc_reg[1] <= ok_c;
                end
                AXIS_Z:
                begin
                    fz_reg     <= neg ? '0 : ip[ZW-1:0];
                    cz_reg     <= neg ? '0 : ce[ZW-1:0];
                    okf_reg[0] <= ok_f;
                    okc_reg[0] <= ok_c;
                end
                default: ;
            endcase
        end
        if (cmd.mark_rd)
        begin
            mk_addr_reg <= vaddr;
            mk_ok_reg   <= (cmd.voxel[2] ? okc_reg[2] : okf_reg[2])
                         && (cmd.voxel[1] ? okc_reg[1] : okf_reg[1])
                         && (cmd.voxel[0] ? okc_reg[0] : okf_reg[0]);
            mk_surf_reg <= vx == '0 || vx == XW'(GRID_X - 1)
                        || vy == '0 || vy == YW'(GRID_Y - 1)
                        || vz == ZW'(GRID_Z - 1);
        end
        if (cmd.load_out)
        begin
            out_reg.mean_error      <= {1'b0, mean_reg};
            out_reg.squared_dev_sum <= dev_reg;
            out_reg.accepted_points <= count_reg;
            out_reg.covered_cells   <= hits_reg;
        end
    end

    assign ram_we    = cmd.clr_step || (cmd.mark_wr && mk_ok_reg);
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : mk_addr_reg;
    assign ram_wdata = !cmd.clr_step;

    pcvcs_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (vaddr),
        .rdata (ram_rdata)
    );

    assign stat.counted  = counted_reg;
    assign stat.clr_last = clr_cnt_reg == AW'(DEPTH - 1);
    assign out_data      = out_reg;

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clr_stats |=> count_reg >= $past(count_reg))
        else $error("point count went down without a clear");

    a_dev_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clr_stats |=> dev_reg >= $past(dev_reg))
        else $error("deviation sum went down without a clear");

    a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clr_stats |=> hits_reg >= $past(hits_reg))
        else $error("covered count went down without a clear");

endmodule

FILE: design/pcvcs_ctrl.sv
// Controller state machine that sequences the datapath for one item.
// Uses pcvcs_pkg.
module pcvcs_ctrl
    import pcvcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_action,
    output logic    in_stall,
    input  logic    out_stall,
    output logic    out_valid,
    input  status_t stat,
    output cmd_t    cmd
);

    typedef enum logic [15:0] {
        ST_CLEAR     = 16'b0000_0000_0000_0001,
        ST_IDLE      = 16'b0000_0000_0000_0010,
        ST_PREP      = 16'b0000_0000_0000_0100,
        ST_SQ        = 16'b0000_0000_0000_1000,
        ST_SQRT_INIT = 16'b0000_0000_0001_0000,
        ST_SQRT      = 16'b0000_0000_0010_0000,
        ST_DECIDE    = 16'b0000_0000_0100_0000,
        ST_DIV_INIT  = 16'b0000_0000_1000_0000,
        ST_DIV       = 16'b0000_0001_0000_0000,
        ST_MEAN      = 16'b0000_0010_0000_0000,
        ST_DEV_MUL   = 16'b0000_0100_0000_0000,
        ST_DEV_ACC   = 16'b0000_1000_0000_0000,
        ST_PROJ      = 16'b0001_0000_0000_0000,
        ST_MARK_RD   = 16'b0010_0000_0000_0000,
        ST_MARK_WR   = 16'b0100_0000_0000_0000,
        ST_DONE      = 16'b1000_0000_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next, cnt_m1;
    logic       reply_reg, reply_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;
    assign cnt_m1   = cnt_reg - 6'd1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        reply_next = reply_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = reply_reg ? ST_DONE : ST_IDLE;
                    reply_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_point = 1'b1;
                    if (in_action == ACTION_CLEAR)
                    begin
                        cmd.clr_stats = 1'b1;
                        reply_next    = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq_issue = cnt_reg < 6'd3;
                cmd.sq_axis  = axis_t'(cnt_reg[1:0]);
                cmd.sq_acc   = cnt_reg != 6'd0;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cnt_next = '0;
                if (stat.counted)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_PROJ;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd30)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                cmd.mean_upd = 1'b1;
                state_next   = ST_DEV_MUL;
            end
            ST_DEV_MUL:
            begin
                cmd.dev_issue = 1'b1;
                state_next    = ST_DEV_ACC;
            end
            ST_DEV_ACC:
            begin
                cmd.dev_acc = 1'b1;
                cnt_next    = '0;
                state_next  = ST_PROJ;
            end
            ST_PROJ:
            begin
                cmd.proj_issue = cnt_reg < 6'd3;
                cmd.proj_axis  = axis_t'(cnt_reg[1:0]);
                cmd.proj_cap   = cnt_reg != 6'd0;
                cmd.cap_axis   = axis_t'(cnt_m1[1:0]);
                cnt_next       = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_MARK_RD;
                end
            end
            ST_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                cmd.voxel   = cnt_reg[2:0];
                state_next  = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                cnt_next    = cnt_reg + 6'd1;
                state_next  = (cnt_reg == 6'd7) ? ST_DONE : ST_MARK_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            reply_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while a transfer is pending");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !cmd.mark_wr && !cmd.load_point)
        else $error("map written by a point during the clearing pass");

    a_reply_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && stat.clr_last && reply_reg) |=> state_reg == ST_DONE)
        else $error("clear transfer did not produce a result");

endmodule

FILE: design/point_cloud_voxel_coverage_stats_core.sv
// Top level of the point cloud voxel coverage statistics core.
// Uses pcvcs_pkg, pcvcs_ctrl and pcvcs_datapath.
//
// Input channel: in_valid/in_stall with in_data carrying an action bit and a
// point in signed Q16.16. Output channel: out_valid/out_stall with out_data
// carrying the running mean, sum of squared deviations, counted points and
// covered surface voxels after the item. Each input transfer gives exactly one
// output transfer. Registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce; cfg_ready is always high.
// One item is worked at a time. A point passes through a 32-step square
// root, a 31-step divider when it is counted, and read-modify-write on the
// voxel map, which has one write and one read port. A clear action sweeps all
// GRID_X*GRID_Y*GRID_Z entries (32768 by default) of the map, one per cycle.
// After reset the same clearing pass runs before in_stall drops.
// The result sits in an output register, so a stalled receiver holds only
// that result; the next item is taken while it waits, and its own result
// waits until the register is free.
module point_cloud_voxel_coverage_stats_core
    import pcvcs_pkg::*;
#(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t    cmd;
    status_t stat;

    assign cfg_ready = 1'b1;

    pcvcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcvcs_datapath #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule
